// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of the project.
// Depends on nothing; each checker takes this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while the active-low reset is held.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed under reset qualifier");

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// File: hw/rtl/ssi_pkg.sv
// Shared types, constants and the key order for the sorted schedule table.
// Depends on nothing; used by the cell, the top level, the checker and the testbench.
package ssi_pkg;

    // Default number of table slots.
    localparam int TableDepthDflt = 16;

    // Widths of the result fields that report a slot or a count.
    localparam int ResFieldW = 5;

    // Action codes of one command.
    localparam logic ActInsert = 1'b0;
    localparam logic ActClear  = 1'b1;

    // One stored schedule key with the handle carried along.
    typedef struct packed {
        logic [31:0] rec_time;
        logic [15:0] orbit_pos;
        logic [31:0] frequency;
        logic [1:0]  polarity;
        logic [15:0] program_number;
        logic [15:0] event_id;
        logic [7:0]  handle;
    } t_key;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic clr;
    } t_cmd;

    // True when the new key belongs ahead of the stored key. Smaller start
    // time first, then larger values of the remaining keys; an exact tie
    // puts the new key first.
    function automatic logic goes_before(input t_key n, input t_key s);
        logic res;
        if (n.rec_time != s.rec_time) begin
            res = (n.rec_time < s.rec_time);
        end else if (n.orbit_pos != s.orbit_pos) begin
            res = (n.orbit_pos > s.orbit_pos);
        end else if (n.frequency != s.frequency) begin
            res = (n.frequency > s.frequency);
        end else if (n.polarity != s.polarity) begin
            res = (n.polarity > s.polarity);
        end else if (n.program_number != s.program_number) begin
            res = (n.program_number > s.program_number);
        end else if (n.event_id != s.event_id) begin
            res = (n.event_id > s.event_id);
        end else begin
            res = 1'b1;
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/ssi_cell.sv
// One slot of the sorted table: holds a key, compares it with the new key
// and takes either the new key or its left neighbor's key. Uses ssi_pkg.
module ssi_cell
    import ssi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_key i_new_key,
    input  t_key i_prev_key,
    input  logic i_prev_valid,
    input  logic i_prev_before,
    output t_key o_key,
    output logic o_valid,
    output logic o_before
);

    t_key r_key;
    logic r_valid;

    // An empty slot or a stored key that the new key precedes.
    assign o_before = !r_valid || goes_before(i_new_key, r_key);

    // Valid flag: clear empties the slot, insert shifts or loads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clr) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ins) begin
            if (i_prev_before) begin
                r_valid <= i_prev_valid;
            end else if (o_before) begin
                r_valid <= 1'b1;
            end
        end
    end

    // Key payload: first slot that the new key precedes loads it, every
    // slot after it takes the key of its left neighbor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && !i_cmd.clr) begin
            if (i_prev_before) begin
                r_key <= i_prev_key;
            end else if (o_before) begin
                r_key <= i_new_key;
            end
        end
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;

endmodule

// File: hw/rtl/schedule_sorted_insert.sv
// Top level of the sorted schedule table: a chain of ssi_cell slots plus
// the result register. Uses ssi_pkg and ssi_cell.
//
//  channel   handshake                   payload
//  --------  --------------------------  -----------------------------------
//  command   start / busy                i_action, i_start_time .. i_handle
//  result    o_done (one-cycle strobe)   o_insert_slot .. o_head_handle
//
// One command is taken per cycle; its result appears on the cycle after the
// transfer. Every slot compares its key with the new key at once and the
// chain shifts in the same edge, so the compare in each cell sets the rate.
// After reset busy stays high until r_ready is set; the table comes up empty.
// The receiver cannot stall: each result is shown for exactly one cycle.
module schedule_sorted_insert
    import ssi_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDflt
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [31:0] i_start_time,
    input  logic [15:0] i_orbit_pos,
    input  logic [31:0] i_frequency,
    input  logic [1:0]  i_polarity,
    input  logic [15:0] i_program_number,
    input  logic [15:0] i_event_id,
    input  logic [7:0]  i_handle,
    output logic        o_done,
    output logic [4:0]  o_insert_slot,
    output logic        o_dropped,
    output logic [4:0]  o_entry_count,
    output logic        o_head_valid,
    output logic [31:0] o_head_start_time,
    output logic [7:0]  o_head_handle
);

    // Width that holds any slot index and the depth itself.
    localparam int SW = $clog2(TABLE_DEPTH + 1);

    logic          r_ready;
    logic          r_done;
    logic [SW-1:0] r_slot;
    logic          r_dropped;
    logic [SW-1:0] r_count;
    logic [SW-1:0] n_slot;
    logic [SW-1:0] n_count;
    logic          n_dropped;
    logic [SW-1:0] slot_enc;
    logic          accept;
    logic          full;
    t_cmd          cmd;
    t_key          new_key;

    t_key                   cell_key    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_valid;
    logic [TABLE_DEPTH-1:0] cell_before;

    logic [SW+ResFieldW-1:0] slot_ext;
    logic [SW+ResFieldW-1:0] count_ext;

    assign busy   = !r_ready;
    assign accept = start && r_ready;
    assign full   = (r_count == SW'(TABLE_DEPTH));

    assign cmd.ins = accept && (i_action == ActInsert);
    assign cmd.clr = accept && (i_action == ActClear);

    assign new_key.rec_time       = i_start_time;
    assign new_key.orbit_pos      = i_orbit_pos;
    assign new_key.frequency      = i_frequency;
    assign new_key.polarity       = i_polarity;
    assign new_key.program_number = i_program_number;
    assign new_key.event_id       = i_event_id;
    assign new_key.handle         = i_handle;

    // The chain of slots; each takes its left neighbor's key on a shift.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            ssi_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (cmd),
                .i_new_key    (new_key),
                .i_prev_key   (new_key),
                .i_prev_valid (1'b0),
                .i_prev_before(1'b0),
                .o_key        (cell_key[g]),
                .o_valid      (cell_valid[g]),
                .o_before     (cell_before[g])
            );
        end else begin : g_rest
            ssi_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (cmd),
                .i_new_key    (new_key),
                .i_prev_key   (cell_key[g-1]),
                .i_prev_valid (cell_valid[g-1]),
                .i_prev_before(cell_before[g-1]),
                .o_key        (cell_key[g]),
                .o_valid      (cell_valid[g]),
                .o_before     (cell_before[g])
            );
        end
    end

    // The before flags form a thermometer; encode its first set position.
    always_comb begin
        slot_enc = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (cell_before[i] && (i == 0 || !cell_before[(i == 0) ? 0 : i - 1])) begin
                slot_enc = slot_enc | SW'(i);
            end
        end
    end

    // Result values of the transfer taken in this cycle.
    always_comb begin
        n_slot    = SW'(TABLE_DEPTH);
        n_dropped = 1'b0;
        n_count   = r_count;
        if (cmd.clr) begin
            n_count = '0;
        end else if (cmd.ins) begin
            n_dropped = full;
            if (cell_before[TABLE_DEPTH-1]) begin
                n_slot = slot_enc;
            end
            if (!full) begin
                n_count = r_count + SW'(1);
            end
        end
    end

    // Control registers: ready after reset, result strobe and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_ready <= 1'b1;
            r_done  <= accept;
            r_count <= n_count;
        end
    end

    // Result payload, loaded with each transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot    <= n_slot;
            r_dropped <= n_dropped;
        end
    end

    // Result ports; the head comes straight from the first slot.
    assign slot_ext          = {{ResFieldW{1'b0}}, r_slot};
    assign count_ext         = {{ResFieldW{1'b0}}, r_count};
    assign o_done            = r_done;
    assign o_insert_slot     = slot_ext[ResFieldW-1:0];
    assign o_dropped         = r_dropped;
    assign o_entry_count     = count_ext[ResFieldW-1:0];
    assign o_head_valid      = cell_valid[0];
    assign o_head_start_time = cell_valid[0] ? cell_key[0].rec_time : '0;
    assign o_head_handle     = cell_valid[0] ? cell_key[0].handle : '0;

endmodule

// File: hw/rtl/ssi_checker.sv
// Port-level checks of schedule_sorted_insert, bound to the top level.
// Depends on ssi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ssi_checker
    import ssi_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDflt
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_action,
    input logic        o_done,
    input logic [4:0]  o_insert_slot,
    input logic        o_dropped,
    input logic [4:0]  o_entry_count,
    input logic        o_head_valid
);

    localparam logic [ResFieldW-1:0] SlotNone = ResFieldW'(TABLE_DEPTH);

    logic accept;
    assign accept = start && !busy;

    // The table is not ready on the cycle after a reset edge.
    `ASSERT_ALWAYS(a_busy_after_reset, i_clk, !i_rst_n |=> busy)

    // Exactly one result per transfer, on the following cycle.
    `ASSERT_RST(a_one_result, i_clk, i_rst_n, o_done == $past(accept))

    // A clear leaves an empty table and stores nothing.
    `ASSERT_RST(a_clear_result, i_clk, i_rst_n,
        o_done && ($past(i_action) == ActClear) |->
            (o_entry_count == '0) && !o_head_valid &&
            (o_insert_slot == SlotNone) && !o_dropped)

    // A loss is only reported from a full table, which stays full.
    `ASSERT_RST(a_drop_full, i_clk, i_rst_n,
        o_done && o_dropped |-> o_entry_count == SlotNone)

    // A table that reports entries also reports a head.
    `ASSERT_RST(a_head_count, i_clk, i_rst_n,
        o_done && (o_entry_count != '0) |-> o_head_valid)

endmodule

bind schedule_sorted_insert ssi_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_ssi_checker (.*);

// File: test/tb_schedule_sorted_insert.sv
// Self-checking testbench for schedule_sorted_insert: directed table plus random
// inserts and clears, each result checked against an in-bench model or fixed value.
// Depends on ssi_pkg and the schedule_sorted_insert RTL.
module tb_schedule_sorted_insert
    import ssi_pkg::*;
();

    localparam int Depth = TableDepthDflt;
    localparam logic [ResFieldW-1:0] NoSlot = ResFieldW'(Depth);
    localparam int NumRandom = 850;
    localparam int StallLimit = 2000;
    localparam int DrainCycles = 8;
    localparam int MaxPrinted = 30;

    // One result as the block reports it.
    typedef struct packed {
        logic [ResFieldW-1:0] slot;
        logic                 dropped;
        logic [ResFieldW-1:0] count;
        logic                 head_valid;
        logic [31:0]          head_start_time;
        logic [7:0]           head_handle;
    } t_outcome;

    // One row of the directed stimulus table.
    typedef struct {
        logic     act;
        t_key     key;
        bit       has_fixed;
        t_outcome fixed;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 drv_act;
    t_key                 drv_key;
    bit                   drv_has_fixed;
    t_outcome             drv_fixed;
    logic                 o_done;
    logic [4:0]           o_insert_slot;
    logic                 o_dropped;
    logic [4:0]           o_entry_count;
    logic                 o_head_valid;
    logic [31:0]          o_head_start_time;
    logic [7:0]           o_head_handle;

    // Model of the schedule table: the valid entries always form a prefix.
    t_key                 sched_tbl [Depth];
    int                   tbl_fill;
    t_outcome             outcome_q [$];
    t_outcome             predicted;
    t_outcome             oldest;

    int                   err_count;
    int                   n_results;
    int                   n_inserts;
    int                   n_clears;
    int                   n_overflows;
    int                   n_rejects;
    int                   stall_cycles;

    schedule_sorted_insert dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (drv_act),
        .i_start_time     (drv_key.rec_time),
        .i_orbit_pos      (drv_key.orbit_pos),
        .i_frequency      (drv_key.frequency),
        .i_polarity       (drv_key.polarity),
        .i_program_number (drv_key.program_number),
        .i_event_id       (drv_key.event_id),
        .i_handle         (drv_key.handle),
        .o_done           (o_done),
        .o_insert_slot    (o_insert_slot),
        .o_dropped        (o_dropped),
        .o_entry_count    (o_entry_count),
        .o_head_valid     (o_head_valid),
        .o_head_start_time(o_head_start_time),
        .o_head_handle    (o_head_handle)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The new key sorts ahead when the stored start time is not smaller and, on a tie,
    // the new secondary keys are not smaller; a full tie puts the new key first.
    function automatic bit key_precedes(input t_key n, input t_key s);
        return {s.rec_time, n.orbit_pos, n.frequency, n.polarity, n.program_number,
                n.event_id} >=
               {n.rec_time, s.orbit_pos, s.frequency, s.polarity, s.program_number,
                s.event_id};
    endfunction

    // Applies one command to the model table and returns the result it should give.
    function automatic t_outcome apply_schedule_cmd(input logic act, input t_key k);
        t_outcome r;
        int       pos;
        int       top;
        bit       found;
        r = '0;
        r.slot = NoSlot;
        if (act == ActClear) begin
            tbl_fill = 0;
        end else begin
            pos = tbl_fill;
            found = 1'b0;
            for (int i = 0; i < tbl_fill; i++) begin
                if (!found && key_precedes(k, sched_tbl[i])) begin
                    pos = i;
                    found = 1'b1;
                end
            end
            r.dropped = (tbl_fill >= Depth);
            // A full table loses its last entry unless the new key itself sorts last.
            if (pos < Depth) begin
                top = (tbl_fill < Depth) ? tbl_fill : Depth - 1;
                for (int i = top; i > pos; i--) begin
                    sched_tbl[i] = sched_tbl[i-1];
                end
                sched_tbl[pos] = k;
                r.slot = ResFieldW'(pos);
                if (tbl_fill < Depth) begin
                    tbl_fill++;
                end
            end
        end
        r.count = ResFieldW'(tbl_fill);
        if (tbl_fill > 0) begin
            r.head_valid = 1'b1;
            r.head_start_time = sched_tbl[0].rec_time;
            r.head_handle = sched_tbl[0].handle;
        end
        return r;
    endfunction

    function automatic t_key mk_key(input logic [31:0] st, input logic [15:0] op,
                                    input logic [31:0] fr, input logic [1:0] pl,
                                    input logic [15:0] pn, input logic [15:0] ev,
                                    input logic [7:0] hd);
        t_key k;
        k.rec_time = st;
        k.orbit_pos = op;
        k.frequency = fr;
        k.polarity = pl;
        k.program_number = pn;
        k.event_id = ev;
        k.handle = hd;
        return k;
    endfunction

    function automatic t_outcome mk_outcome(input logic [4:0] slot, input logic drop,
                                            input logic [4:0] cnt, input logic hv,
                                            input logic [31:0] hst, input logic [7:0] hhd);
        t_outcome r;
        r.slot = slot;
        r.dropped = drop;
        r.count = cnt;
        r.head_valid = hv;
        r.head_start_time = hst;
        r.head_handle = hhd;
        return r;
    endfunction

    task automatic log_mismatch(input string what);
        err_count++;
        if (err_count <= MaxPrinted) begin
            $display("MISMATCH at %0t, result %0d: %s", $time, n_results, what);
        end
    endtask

    // Presents one command from a falling edge on and returns once it has transferred.
    task automatic send_cmd(input logic act, input t_key k, input bit has_fixed,
                            input t_outcome fixed, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        drv_act <= act;
        drv_key <= k;
        drv_has_fixed <= has_fixed;
        drv_fixed <= fixed;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Holds the command side off until every outstanding result has come back.
    task automatic wait_drained;
        @(negedge i_clk);
        start <= 1'b0;
        while (outcome_q.size() != 0) @(negedge i_clk);
    endtask

    // Transfers in both directions: predict on a command, compare on a result.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (start === 1'b1 && busy === 1'b0) begin
                predicted = apply_schedule_cmd(drv_act, drv_key);
                if (drv_act == ActClear) begin
                    n_clears++;
                end else begin
                    n_inserts++;
                end
                if (predicted.dropped) begin
                    n_overflows++;
                    if (predicted.slot == NoSlot) begin
                        n_rejects++;
                    end
                end
                outcome_q.push_back(drv_has_fixed ? drv_fixed : predicted);
            end
            if (o_done === 1'b1) begin
                n_results++;
                if (outcome_q.size() == 0) begin
                    log_mismatch("result strobe with no command waiting for it");
                end else begin
                    oldest = outcome_q.pop_front();
                    if (o_insert_slot !== oldest.slot)
                        log_mismatch($sformatf("insert_slot %0d, wanted %0d",
                                               o_insert_slot, oldest.slot));
                    if (o_dropped !== oldest.dropped)
                        log_mismatch($sformatf("dropped %b, wanted %b",
                                               o_dropped, oldest.dropped));
                    if (o_entry_count !== oldest.count)
                        log_mismatch($sformatf("entry_count %0d, wanted %0d",
                                               o_entry_count, oldest.count));
                    if (o_head_valid !== oldest.head_valid)
                        log_mismatch($sformatf("head_valid %b, wanted %b",
                                               o_head_valid, oldest.head_valid));
                    if (o_head_start_time !== oldest.head_start_time)
                        log_mismatch($sformatf("head_start_time %h, wanted %h",
                                               o_head_start_time, oldest.head_start_time));
                    if (o_head_handle !== oldest.head_handle)
                        log_mismatch($sformatf("head_handle %h, wanted %h",
                                               o_head_handle, oldest.head_handle));
                end
            end
        end
    end

    // Watchdog: too many cycles in a row without any transfer ends the run.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= StallLimit) begin
            $display("Timeout: no transfer for %0d cycles", StallLimit);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_row     dir_rows [$];
        t_row     row;
        t_key     k;
        t_key     prev_key;
        t_outcome none;
        t_outcome cleared;
        logic     act;
        int       sel;
        int       gap;
        bit       burst;
        int       burst_left;

        none = '0;
        cleared = mk_outcome(NoSlot, 1'b0, 5'd0, 1'b0, 32'd0, 8'd0);
        tbl_fill = 0;
        err_count = 0;
        n_results = 0;
        n_inserts = 0;
        n_clears = 0;
        n_overflows = 0;
        n_rejects = 0;
        stall_cycles = 0;
        burst = 1'b0;
        burst_left = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        drv_act = ActInsert;
        drv_key = '0;
        drv_has_fixed = 1'b0;
        drv_fixed = '0;

        // Directed table: empty table, clears, key extremes, exact tie, each tie-break
        // key, filling up, and both kinds of overflow.
        row.act = ActInsert;
        row.key = mk_key(32'd100, 16'd5, 32'd1000, 2'd1, 16'd7, 16'd9, 8'h11);
        row.has_fixed = 1'b1;
        row.fixed = mk_outcome(5'd0, 1'b0, 5'd1, 1'b1, 32'd100, 8'h11);
        dir_rows.push_back(row);
        row.act = ActClear;
        row.fixed = cleared;
        dir_rows.push_back(row);
        dir_rows.push_back(row);
        row.act = ActInsert;
        row.key = mk_key('1, '1, '1, '1, '1, '1, '1);
        row.fixed = mk_outcome(5'd0, 1'b0, 5'd1, 1'b1, 32'hFFFF_FFFF, 8'hFF);
        dir_rows.push_back(row);
        row.key = mk_key('0, '0, '0, '0, '0, '0, '0);
        row.fixed = mk_outcome(5'd0, 1'b0, 5'd2, 1'b1, 32'd0, 8'h00);
        dir_rows.push_back(row);
        // An exact tie goes ahead of the stored equal entry.
        row.key = mk_key('0, '0, '0, '0, '0, '0, 8'h5A);
        row.fixed = mk_outcome(5'd0, 1'b0, 5'd3, 1'b1, 32'd0, 8'h5A);
        dir_rows.push_back(row);
        row.has_fixed = 1'b0;
        row.fixed = none;
        row.key = mk_key('0, 16'd1, '0, '0, '0, '0, 8'h21);
        dir_rows.push_back(row);
        row.key = mk_key('0, '0, 32'd1, '0, '0, '0, 8'h22);
        dir_rows.push_back(row);
        row.key = mk_key('0, '0, '0, 2'd1, '0, '0, 8'h23);
        dir_rows.push_back(row);
        row.key = mk_key('0, '0, '0, '0, 16'd1, '0, 8'h24);
        dir_rows.push_back(row);
        row.key = mk_key('0, '0, '0, '0, '0, 16'd1, 8'h25);
        dir_rows.push_back(row);
        for (int i = 0; i < 8; i++) begin
            row.key = mk_key(32'd2000 - 32'(100 * i), 16'(i), '0, '0, '0, '0, 8'(8'h30 + i));
            dir_rows.push_back(row);
        end
        // Table is full now; this key sorts after everything and is turned away.
        row.key = mk_key('1, '0, '0, '0, '0, '0, 8'h40);
        dir_rows.push_back(row);
        // Full table, the new key sorts first and the last entry falls off.
        row.key = mk_key('0, '1, '0, '0, '0, '0, 8'h41);
        row.has_fixed = 1'b1;
        row.fixed = mk_outcome(5'd0, 1'b1, 5'd16, 1'b1, 32'd0, 8'h41);
        dir_rows.push_back(row);
        row.act = ActClear;
        row.fixed = cleared;
        dir_rows.push_back(row);
        row.act = ActInsert;
        row.key = mk_key(32'd7, 16'd3, 32'd3, 2'd2, 16'd3, 16'd3, 8'h55);
        row.fixed = mk_outcome(5'd0, 1'b0, 5'd1, 1'b1, 32'd7, 8'h55);
        dir_rows.push_back(row);

        // Synchronous reset, released on a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_cmd(dir_rows[i].act, dir_rows[i].key, dir_rows[i].has_fixed,
                     dir_rows[i].fixed, $urandom_range(0, 3));
        end
        wait_drained();

        // Random part: mostly inserts so the table fills and overflows, rare clears.
        // Narrow keys make ties on the leading keys common; repeats give exact ties.
        prev_key = '0;
        for (int n = 0; n < NumRandom; n++) begin
            if (burst_left == 0) begin
                burst = ($urandom_range(0, 3) == 0);
                burst_left = $urandom_range(20, 60);
            end
            burst_left--;
            gap = burst ? 0 : $urandom_range(0, 15);
            if (n > 0 && n % 200 == 0) begin
                wait_drained();
            end
            act = ($urandom_range(0, 23) == 0) ? ActClear : ActInsert;
            sel = $urandom_range(0, 7);
            if (sel == 0) begin
                k = prev_key;
                k.handle = 8'($urandom_range(0, 255));
            end else if (sel < 4) begin
                k = mk_key(32'($urandom_range(0, 15)), 16'($urandom_range(0, 3)),
                           32'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                           16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)));
            end else begin
                k = mk_key($urandom(), 16'($urandom_range(0, 65535)), $urandom(),
                           2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            end
            prev_key = k;
            send_cmd(act, k, 1'b0, none, gap);
        end

        // Let every result come back, then keep watching for stray strobes.
        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (outcome_q.size() != 0) begin
            log_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
        end

        $display("Ran %0d commands (%0d inserts, %0d clears), checked %0d results.",
                 n_inserts + n_clears, n_inserts, n_clears, n_results);
        $display("Table overflowed %0d times; %0d new entries were turned away.",
                 n_overflows, n_rejects);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
